@@ design/hex_count_run_length_decoder_defines.svh @@
// Assertion macros shared by the run-length decoder RTL.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef HEX_COUNT_RUN_LENGTH_DECODER_DEFINES_SVH
`define HEX_COUNT_RUN_LENGTH_DECODER_DEFINES_SVH

// check that is masked while reset is high
`define HCRL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds across reset
`define HCRL_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/hcrl_pkg.sv @@
// Types, codes and helpers for the hex-count run-length decoder.
// No dependencies; used by hcrl_step and the top level.
package hcrl_pkg;

   localparam logic [7:0] STAR_CHAR = 8'h2A;

   // decode phase of the current message
   typedef enum logic [1:0] {
      PH_NORMAL  = 2'd0,
      PH_DIGIT1  = 2'd1,
      PH_DIGIT2  = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   // one request: a character of the encoded message
   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   // one result: a run of bytes, or the error marker
   typedef struct packed {
      logic [7:0] run_byte;
      logic [7:0] run_count;
      logic       decode_error;
      logic       out_last;
   } rsp_type;

   // per-message decode state
   typedef struct packed {
      phase_type  phase;
      logic [7:0] previous_char;
      logic [3:0] first_count_digit;
      logic       seen_any_char;
   } state_type;

   // hex digit lookup: valid flag and digit value
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   localparam state_type STATE_RESET = '{
      phase:             PH_NORMAL,
      previous_char:     8'h00,
      first_count_digit: 4'h0,
      seen_any_char:     1'b0
   };

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      logic [7:0] d;
      h = '{valid: 1'b0, value: 4'h0};
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
         h = '{valid: 1'b1, value: d[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h61 + 8'd10;
         h = '{valid: 1'b1, value: d[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h41 + 8'd10;
         h = '{valid: 1'b1, value: d[3:0]};
      end
      return h;
   endfunction

endpackage

@@ design/hex_count_run_length_decoder.sv @@
// Hex-count run-length decoder, top level.
// Depends on hcrl_pkg, hcrl_step and hex_count_run_length_decoder_defines.svh.
//
// Usage:
//   The req channel takes one character of an encoded message per request,
//   with in_last on the final character. A plain character gives a run of
//   one; a star and two hex digits repeat the character before the star.
//   The rsp channel gives runs (run_byte, run_count), or one error result
//   with decode_error set, run_count zero and out_last set at the end of a
//   malformed message; earlier runs of that message are then void.
//   Result: registered; it appears in the cycle after its request is accepted.
//   Throughput: one request per cycle; the decode is a single combinational
//   step between the message state register and the result register.
//   Requests that only advance the count digits give no result.
//   Stall: while a result waits in the result register and rsp_ready is
//   low, req_ready drops; requests flow again in the cycle it is taken.
//   Reset: synchronous, clears the message state and empties the result
//   register.
`include "hex_count_run_length_decoder_defines.svh"

module hex_count_run_length_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hcrl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hcrl_pkg::rsp_type rsp_data
);

   hcrl_pkg::state_type state_ff;
   hcrl_pkg::state_type state_in;
   hcrl_pkg::rsp_type   rsp_ff;
   hcrl_pkg::rsp_type   step_result;
   logic                step_valid;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                req_fire;

   // decode step
   hcrl_step u_step (
      .state        (state_ff),
      .req          (req_data),
      .state_next   (state_in),
      .result_valid (step_valid),
      .result       (step_result)
   );

   // handshake: accept while the result register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && step_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // message state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcrl_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire && step_valid) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `HCRL_ASSERT(a_error_shape, rsp_valid_ff && rsp_ff.decode_error |-> rsp_ff.run_count == 8'h00 && rsp_ff.out_last, "error result must be final with zero count")
   `HCRL_ASSERT(a_run_nonzero, rsp_valid_ff && !rsp_ff.decode_error |-> rsp_ff.run_count != 8'h00, "run result with zero count")
   `HCRL_ASSERT(a_last_clears, req_fire && req_data.in_last |=> state_ff.phase == hcrl_pkg::PH_NORMAL && !state_ff.seen_any_char, "state not cleared after last request")
   `HCRL_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

@@ design/hcrl_step.sv @@
// Combinational decode of one request against the current message state.
// Depends on hcrl_pkg.
module hcrl_step (
   input  hcrl_pkg::state_type state,
   input  hcrl_pkg::req_type   req,
   output hcrl_pkg::state_type state_next,
   output logic                result_valid,
   output hcrl_pkg::rsp_type   result
);

   hcrl_pkg::hex_type digit;
   logic [7:0]        count;
   logic              is_star;

   // count from one or two hex digits
   assign digit   = hcrl_pkg::hex_digit(req.in_char);
   assign is_star = (req.in_char == hcrl_pkg::STAR_CHAR);
   assign count   = digit.valid ? {state.first_count_digit, digit.value}
                                : {4'h0, state.first_count_digit};

   // next state
   always_comb begin
      state_next = state;
      state_next.seen_any_char = 1'b1;
      case (state.phase)
         hcrl_pkg::PH_NORMAL: begin
            if (is_star) begin
               if (!state.seen_any_char || req.in_last) begin
                  state_next.phase = hcrl_pkg::PH_DISCARD;
               end else begin
                  state_next.phase = hcrl_pkg::PH_DIGIT1;
               end
            end else begin
               state_next.previous_char = req.in_char;
            end
         end
         hcrl_pkg::PH_DIGIT1: begin
            if (!digit.valid || req.in_last) begin
               state_next.phase = hcrl_pkg::PH_DISCARD;
            end else begin
               state_next.first_count_digit = digit.value;
               state_next.phase = hcrl_pkg::PH_DIGIT2;
            end
         end
         hcrl_pkg::PH_DIGIT2: begin
            if (count == 8'h00) begin
               state_next.phase = hcrl_pkg::PH_DISCARD;
            end else begin
               state_next.previous_char = req.in_char;
               state_next.phase = hcrl_pkg::PH_NORMAL;
            end
         end
         default: begin
            state_next.phase = hcrl_pkg::PH_DISCARD;
         end
      endcase
      // end of message starts the next one clean
      if (req.in_last) begin
         state_next = hcrl_pkg::STATE_RESET;
      end
   end

   // result for this request
   always_comb begin
      result_valid = 1'b0;
      result = '{run_byte: 8'h00, run_count: 8'h00, decode_error: 1'b1, out_last: 1'b1};
      case (state.phase)
         hcrl_pkg::PH_NORMAL: begin
            if (!is_star) begin
               result_valid = 1'b1;
               result = '{run_byte: req.in_char, run_count: 8'd1,
                          decode_error: 1'b0, out_last: req.in_last};
            end else begin
               result_valid = req.in_last;
            end
         end
         hcrl_pkg::PH_DIGIT1: begin
            result_valid = req.in_last;
         end
         hcrl_pkg::PH_DIGIT2: begin
            if (count != 8'h00) begin
               result_valid = 1'b1;
               result = '{run_byte: state.previous_char, run_count: count,
                          decode_error: 1'b0, out_last: req.in_last};
            end else begin
               result_valid = req.in_last;
            end
         end
         default: begin
            result_valid = req.in_last;
         end
      endcase
   end

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the hex-count run-length decoder: directed and random
// messages, randomly idled request and result channels, in-bench run prediction.
// Depends on hcrl_pkg and the hex_count_run_length_decoder top level.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned RANDOM_ITEMS     = 1850;
   localparam int unsigned LONG_HOLD_AT     = 300;
   localparam int unsigned LONG_HOLD_CYCLES = 60;
   // worst legal quiet stretch is the long result hold plus a few idle draws
   localparam int unsigned IDLE_LIMIT       = 2000;
   localparam int unsigned MAX_REPORTS      = 10;

   // one queued character with its lead-in gap, or a wait-for-drain marker
   typedef struct {
      hcrl_pkg::req_type data;
      int unsigned       gap;
      bit                drain;
   } char_slot_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   hcrl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   hcrl_pkg::rsp_type rsp_data;

   char_slot_type     char_q[$];
   hcrl_pkg::rsp_type runs_due[$];

   // message state of the predictor
   hcrl_pkg::phase_type msg_phase = hcrl_pkg::PH_NORMAL;
   logic [7:0]          prev_char = 8'h00;
   logic [3:0]          count_hi = 4'h0;
   bit                  msg_seen = 1'b0;

   bit            req_fire = 1'b0;
   bit            rsp_fire = 1'b0;
   int unsigned   fault_count = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   n_queued = 0;

   // sender state
   int unsigned       gap_waited = 0;
   logic              nxt_valid;
   hcrl_pkg::req_type nxt_data;
   char_slot_type     cur_slot;

   // receiver state
   bit            rsp_armed = 1'b0;
   int unsigned   rsp_stall = 0;
   int unsigned   runs_taken = 0;

   // monitor scratch
   hcrl_pkg::rsp_type run_want;
   hcrl_pkg::rsp_type run_new;

   hex_count_run_length_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hex digit value of a character, 0 if it is not a hex digit
   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      logic [7:0] d;
      d = 8'h00;
      v = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h41 + 8'd10;
      end else begin
         return 1'b0;
      end
      v = d[3:0];
      return 1'b1;
   endfunction

   // advance the message state by one character; returns 1 when a run comes out
   function automatic bit decode_char(input hcrl_pkg::req_type rq,
                                      output hcrl_pkg::rsp_type run);
      logic [3:0] nib;
      logic [7:0] cnt;
      bit         was_seen;
      bit         is_hex;
      bit         bad;
      bit         has_run;
      run = '0;
      has_run = 1'b0;
      bad = 1'b0;
      was_seen = msg_seen;
      msg_seen = 1'b1;
      case (msg_phase)
         hcrl_pkg::PH_NORMAL: begin
            if (rq.in_char == hcrl_pkg::STAR_CHAR) begin
               if (!was_seen || rq.in_last) bad = 1'b1;
               else msg_phase = hcrl_pkg::PH_DIGIT1;
            end else begin
               prev_char = rq.in_char;
               run = '{rq.in_char, 8'd1, 1'b0, rq.in_last};
               has_run = 1'b1;
            end
         end
         hcrl_pkg::PH_DIGIT1: begin
            is_hex = hex_nibble(rq.in_char, nib);
            if (!is_hex || rq.in_last) begin
               bad = 1'b1;
            end else begin
               count_hi = nib;
               msg_phase = hcrl_pkg::PH_DIGIT2;
            end
         end
         hcrl_pkg::PH_DIGIT2: begin
            // a non-hex second digit leaves the first digit as the whole count
            is_hex = hex_nibble(rq.in_char, nib);
            cnt = is_hex ? {count_hi, nib} : {4'h0, count_hi};
            if (cnt == 8'd0) begin
               bad = 1'b1;
            end else begin
               run = '{prev_char, cnt, 1'b0, rq.in_last};
               has_run = 1'b1;
               prev_char = rq.in_char;
               msg_phase = hcrl_pkg::PH_NORMAL;
            end
         end
         default: begin
            bad = rq.in_last;
         end
      endcase
      if (bad && rq.in_last) begin
         run = '{8'h00, 8'h00, 1'b1, 1'b1};
         has_run = 1'b1;
      end else if (bad) begin
         msg_phase = hcrl_pkg::PH_DISCARD;
      end
      // every message starts from a clean state
      if (rq.in_last) begin
         msg_phase = hcrl_pkg::PH_NORMAL;
         prev_char = 8'h00;
         count_hi = 4'h0;
         msg_seen = 1'b0;
      end
      return has_run;
   endfunction

   task automatic log_fault(input string what, input hcrl_pkg::rsp_type want,
                            input hcrl_pkg::rsp_type got);
      if (fault_count < MAX_REPORTS)
         $display("tb: %s at %0t: want %02h/%0d/%0b/%0b, got %02h/%0d/%0b/%0b",
                  what, $realtime, want.run_byte, want.run_count, want.decode_error,
                  want.out_last, got.run_byte, got.run_count, got.decode_error,
                  got.out_last);
      fault_count++;
   endtask

   // queue one character; the gap pattern has runs of zero-gap requests
   task automatic push_char(input logic [7:0] c, input bit is_last);
      char_slot_type s;
      s.data = '{in_char: c, in_last: is_last};
      s.gap = ((n_queued / 100) % 4 == 1) ? 0 : $urandom_range(0, 4);
      s.drain = 1'b0;
      char_q = {char_q, s};
      n_queued++;
   endtask

   task automatic push_text(input string txt, input bit last_at_end);
      for (int i = 0; i < txt.len(); i++)
         push_char(txt[i], last_at_end && (i == txt.len() - 1));
   endtask

   task automatic push_drain();
      char_slot_type s;
      s.data = '0;
      s.gap = 0;
      s.drain = 1'b1;
      char_q = {char_q, s};
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) != 0) ? 8'h41 + 8'(v) - 8'd10 : 8'h61 + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      logic [3:0] v;
      do c = 8'($urandom); while (hex_nibble(c, v));
      return c;
   endfunction

   // one random message: mostly well-formed runs, some truncated, some noise
   task automatic queue_message();
      logic [7:0] msg[$];
      logic [7:0] c;
      int         mode;
      int         toks;
      int         keep;
      mode = $urandom_range(0, 9);
      toks = $urandom_range(1, 7);
      if (mode == 0) begin
         for (int i = 0; i < toks + 1; i++) begin
            case ($urandom_range(0, 3))
               0:       msg = {msg, hcrl_pkg::STAR_CHAR};
               1:       msg = {msg, hex_char(4'($urandom))};
               default: msg = {msg, 8'($urandom)};
            endcase
         end
      end else begin
         for (int t = 0; t < toks; t++) begin
            if (t == 0 || $urandom_range(0, 9) < 6) begin
               do c = 8'($urandom); while (c == hcrl_pkg::STAR_CHAR);
               msg = {msg, c};
            end else begin
               msg = {msg, hcrl_pkg::STAR_CHAR};
               if ($urandom_range(0, 29) == 0) begin
                  // zero count
                  msg = {msg, 8'h30};
                  msg = {msg, (($urandom_range(0, 1) != 0) ? 8'h30 : non_hex_char())};
               end else begin
                  msg = {msg, hex_char(4'($urandom))};
                  msg = {msg, (($urandom_range(0, 6) == 0) ? non_hex_char()
                                                           : hex_char(4'($urandom)))};
               end
            end
         end
         // broken sequence: cut the message short anywhere
         if (mode == 1) begin
            keep = $urandom_range(1, msg.size());
            while (msg.size() > keep) void'(msg.pop_back());
         end
      end
      foreach (msg[i]) push_char(msg[i], i == msg.size() - 1);
   endtask

   // request driver
   always @(negedge clock) begin
      nxt_valid = req_valid;
      nxt_data = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || req_fire) begin
         nxt_valid = 1'b0;
         if (char_q.size() != 0) begin
            if (char_q[0].drain) begin
               if (runs_due.size() == 0) void'(char_q.pop_front());
            end else if (gap_waited < char_q[0].gap) begin
               gap_waited++;
            end else begin
               cur_slot = char_q.pop_front();
               nxt_valid = 1'b1;
               nxt_data = cur_slot.data;
               gap_waited = 0;
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
   end

   // result receiver with random stalls and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fire || !rsp_armed) begin
            rsp_armed = 1'b1;
            if (rsp_fire) runs_taken++;
            if (rsp_fire && runs_taken == LONG_HOLD_AT) rsp_stall = LONG_HOLD_CYCLES;
            else if ((runs_taken / 48) % 3 == 0) rsp_stall = 0;
            else rsp_stall = $urandom_range(0, 4);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: check taken runs first, then predict for the accepted request
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (runs_due.size() == 0) begin
               log_fault("unexpected run", '0, rsp_data);
            end else begin
               run_want = runs_due.pop_front();
               if (rsp_data.run_byte !== run_want.run_byte ||
                   rsp_data.run_count !== run_want.run_count ||
                   rsp_data.decode_error !== run_want.decode_error ||
                   rsp_data.out_last !== run_want.out_last)
                  log_fault("run mismatch", run_want, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            if (decode_char(req_data, run_new)) runs_due = {runs_due, run_new};
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      // star first in the message, then discard up to the last character
      push_text("*q", 1'b1);
      // byte extremes and the largest count
      push_char(8'h00, 1'b0);
      push_text("*fF", 1'b0);
      push_char(8'hFF, 1'b1);
      // star as the last character
      push_text("c*", 1'b1);
      // message ends after the first count digit
      push_text("d*5", 1'b1);
      // first count digit not hex
      push_text("e*g", 1'b1);
      // non-hex second digit giving a zero count
      push_text("m*0z", 1'b1);
      // repeat copies the raw second digit of the earlier repeat; short count
      push_text("p*12*7!", 1'b1);
      push_drain();

      while (n_queued < 26 + RANDOM_ITEMS) begin
         queue_message();
         if (n_queued >= 26 + RANDOM_ITEMS / 2 && n_queued < 26 + RANDOM_ITEMS / 2 + 8)
            push_drain();
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || req_valid) @(negedge clock);
      while (runs_due.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);

      if (fault_count == 0 && runs_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/hcrl_pkg.sv
design/hcrl_step.sv
design/hex_count_run_length_decoder.sv
tb/tb.sv
